// ===== design/point_convex_polyhedron_contact_core_macros.svh =====
// assertion macros for the point convex polyhedron contact core
// used by the port checker, no other dependencies
`ifndef POINT_CONVEX_POLYHEDRON_CONTACT_CORE_MACROS_SVH
`define POINT_CONVEX_POLYHEDRON_CONTACT_CORE_MACROS_SVH

// checked only outside reset
`define PCPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define PCPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pcpc_pkg.sv =====
// shared types and constants of the point convex polyhedron contact core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcpc_pkg;

  // fraction bits of the q16.16 coordinates
  localparam int unsigned FRAC_BITS = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic init;   // latch point, clear accumulators
    logic load;   // write one face into the table
    logic issue;  // read one face into the pipeline
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/pcpc_ctrl.sv =====
// controller of the contact core: face count register and query sequencer
// depends on pcpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcpc_ctrl #(
  parameter int unsigned MAX_FACES = 64
) (
  input  wire  logic                         clk_i,
  input  wire  logic                         rst_ni,
  input  wire  logic                         start,
  input  wire  logic                         operation_i,
  input  wire  logic                         cfg_we_i,
  input  wire  logic [6:0]                   cfg_wdata_i,
  input  wire  logic                         pipe_busy_i,
  output       logic                         busy,
  output       logic                         done_o,
  output       pcpc_pkg::cmd_t               cmd_o,
  output       logic [$clog2(MAX_FACES)-1:0] rd_addr_o
);

  localparam int unsigned AW = $clog2(MAX_FACES);
  localparam int unsigned CW = $clog2(MAX_FACES + 1);

  pcpc_pkg::state_e state_q, state_d;
  logic [6:0]       face_count_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    n_clamped;
  logic             accept;

  assign accept = start && (state_q == pcpc_pkg::ST_IDLE);
  assign busy   = (state_q != pcpc_pkg::ST_IDLE);
  assign done_o = (state_q == pcpc_pkg::ST_DONE);

  always_comb begin
    if (32'(face_count_q) > 32'(MAX_FACES)) begin
      n_clamped = CW'(MAX_FACES);
    end else begin
      n_clamped = CW'(face_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_count_q <= 7'd1;
    end else if (cfg_we_i) begin
      face_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    cmd_o     = '0;
    rd_addr_o = cnt_q[AW-1:0];
    unique case (state_q)
      pcpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == pcpc_pkg::OP_QUERY) begin
            cmd_o.init = 1'b1;
            cnt_d      = '0;
            n_d        = n_clamped;
            state_d    = pcpc_pkg::ST_RUN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      pcpc_pkg::ST_RUN: begin
        if (cnt_q == n_q) begin
          state_d = pcpc_pkg::ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          cnt_d       = CW'(cnt_q + 1'b1);
        end
      end
      pcpc_pkg::ST_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = pcpc_pkg::ST_DONE;
        end
      end
      pcpc_pkg::ST_DONE: begin
        state_d = pcpc_pkg::ST_IDLE;
      end
      default: begin
        state_d = pcpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcpc_pkg::ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcpc_datapath.sv =====
// datapath of the contact core: face table, depth pipeline and min tracker
// depends on pcpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcpc_datapath #(
  parameter int unsigned MAX_FACES  = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire  logic                         clk_i,
  input  wire  logic                         rst_ni,
  input  wire  pcpc_pkg::cmd_t               cmd_i,
  input  wire  logic [$clog2(MAX_FACES)-1:0] rd_addr_i,
  input  wire  logic [5:0]                   face_index_i,
  input  wire  logic [31:0]                  normal_x_i,
  input  wire  logic [31:0]                  normal_y_i,
  input  wire  logic [31:0]                  normal_z_i,
  input  wire  logic [31:0]                  vertex_x_i,
  input  wire  logic [31:0]                  vertex_y_i,
  input  wire  logic [31:0]                  vertex_z_i,
  input  wire  logic [31:0]                  point_x_i,
  input  wire  logic [31:0]                  point_y_i,
  input  wire  logic [31:0]                  point_z_i,
  output       logic                         pipe_busy_o,
  output       logic                         inside_res_o,
  output       logic [31:0]                  penetration_o,
  output       logic [31:0]                  contact_normal_x_o,
  output       logic [31:0]                  contact_normal_y_o,
  output       logic [31:0]                  contact_normal_z_o
);

  localparam int unsigned AW = $clog2(MAX_FACES);
  localparam int unsigned IW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int unsigned DW = IW + 1;
  localparam int unsigned PW = 2 * IW + 1;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned CB = COORD_BITS;
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB - 1){1'b1}}};

  // face table, one row holds normal xyz then vertex xyz
  logic [6*IW-1:0] face_mem [MAX_FACES];
  logic [6*IW-1:0] rd_q;

  logic [AW+5:0] idx_ext;
  logic [AW-1:0] wr_addr;
  logic          slot_ok;

  assign idx_ext = (AW + 6)'(face_index_i);
  assign wr_addr = idx_ext[AW-1:0];
  assign slot_ok = 32'(face_index_i) < 32'(MAX_FACES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      face_mem[wr_addr] <= {normal_x_i[IW-1:0], normal_y_i[IW-1:0], normal_z_i[IW-1:0],
                            vertex_x_i[IW-1:0], vertex_y_i[IW-1:0], vertex_z_i[IW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= face_mem[rd_addr_i];
    end
  end

  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], cmd_i.issue};
    end
  end

  assign pipe_busy_o = |vld_q;

  // query point
  logic signed [IW-1:0] pt_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      pt_q[0] <= point_x_i[IW-1:0];
      pt_q[1] <= point_y_i[IW-1:0];
      pt_q[2] <= point_z_i[IW-1:0];
    end
  end

  logic signed [IW-1:0] rd_nrm [3];
  logic signed [IW-1:0] rd_vtx [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_nrm[i] = rd_q[(5 - i) * IW +: IW];
      rd_vtx[i] = rd_q[(2 - i) * IW +: IW];
    end
  end

  // stage 1: vertex minus point
  logic signed [DW-1:0] diff_q [3];
  logic signed [IW-1:0] nrm1_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      diff_q[i] <= DW'(rd_vtx[i]) - DW'(pt_q[i]);
      nrm1_q[i] <= rd_nrm[i];
    end
  end

  // stage 2: exact products
  logic signed [PW-1:0] prod_q [3];
  logic signed [IW-1:0] nrm2_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= PW'(nrm1_q[i]) * PW'(diff_q[i]);
      nrm2_q[i] <= nrm1_q[i];
    end
  end

  // stage 3: sum, floor shift, saturate
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sh;
  logic signed [CB-1:0] depth_sat;
  logic signed [CB-1:0] depth_q;
  logic signed [IW-1:0] nrm3_q [3];

  always_comb begin
    sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
    sh  = sum >>> pcpc_pkg::FRAC_BITS;
    if ((&sh[SW-1:CB-1]) || !(|sh[SW-1:CB-1])) begin
      depth_sat = sh[CB-1:0];
    end else if (sh[SW-1]) begin
      depth_sat = ~COORD_MAX;
    end else begin
      depth_sat = COORD_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q <= depth_sat;
    for (int i = 0; i < 3; i++) begin
      nrm3_q[i] <= nrm2_q[i];
    end
  end

  // stage 4: outside flag and first strict minimum
  logic                 outside_q;
  logic                 have_q;
  logic signed [CB-1:0] best_q;
  logic signed [IW-1:0] best_nrm_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= 1'b0;
      have_q    <= 1'b0;
    end else if (cmd_i.init) begin
      outside_q <= 1'b0;
      have_q    <= 1'b0;
    end else if (vld_q[3]) begin
      if (depth_q[CB-1]) begin
        outside_q <= 1'b1;
      end else if (!have_q || (depth_q < best_q)) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      best_q <= COORD_MAX;
      for (int i = 0; i < 3; i++) begin
        best_nrm_q[i] <= '0;
      end
    end else if (vld_q[3] && !depth_q[CB-1] && (!have_q || (depth_q < best_q))) begin
      best_q <= depth_q;
      for (int i = 0; i < 3; i++) begin
        best_nrm_q[i] <= nrm3_q[i];
      end
    end
  end

  logic signed [CB-1:0] neg_best;

  assign neg_best           = -best_q;
  assign inside_res_o       = !outside_q;
  assign penetration_o      = outside_q ? 32'd0 : 32'(neg_best);
  assign contact_normal_x_o = outside_q ? 32'd0 : 32'(best_nrm_q[0]);
  assign contact_normal_y_o = outside_q ? 32'd0 : 32'(best_nrm_q[1]);
  assign contact_normal_z_o = outside_q ? 32'd0 : 32'(best_nrm_q[2]);

endmodule

`default_nettype wire

// ===== design/point_convex_polyhedron_contact_core.sv =====
// query: the face walk reads n table rows, one per cycle, n being face_count clamped to
// MAX_FACES, through a five stage depth pipeline that drains before done_o.
// a query holds busy high through done_o; a face load leaves busy low.
// done_o lasts one cycle and cannot be stalled.
// reset: asynchronous active low; face_count becomes 1, the face table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_convex_polyhedron_contact_core #(
  parameter int unsigned MAX_FACES  = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        start,
  output       logic        busy,
  input  wire  logic        cfg_we_i,
  input  wire  logic [6:0]  cfg_wdata_i,
  input  wire  logic        operation_i,
  input  wire  logic [5:0]  face_index_i,
  input  wire  logic [31:0] normal_x_i,
  input  wire  logic [31:0] normal_y_i,
  input  wire  logic [31:0] normal_z_i,
  input  wire  logic [31:0] vertex_x_i,
  input  wire  logic [31:0] vertex_y_i,
  input  wire  logic [31:0] vertex_z_i,
  input  wire  logic [31:0] point_x_i,
  input  wire  logic [31:0] point_y_i,
  input  wire  logic [31:0] point_z_i,
  output       logic        done_o,
  output       logic        inside_res_o,
  output       logic [31:0] penetration_o,
  output       logic [31:0] contact_normal_x_o,
  output       logic [31:0] contact_normal_y_o,
  output       logic [31:0] contact_normal_z_o
);

  pcpc_pkg::cmd_t               cmd;
  logic [$clog2(MAX_FACES)-1:0] rd_addr;
  logic                         pipe_busy;

  pcpc_ctrl #(
    .MAX_FACES(MAX_FACES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(operation_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pipe_busy_i(pipe_busy),
    .busy       (busy),
    .done_o     (done_o),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  pcpc_datapath #(
    .MAX_FACES (MAX_FACES),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rd_addr_i         (rd_addr),
    .face_index_i      (face_index_i),
    .normal_x_i        (normal_x_i),
    .normal_y_i        (normal_y_i),
    .normal_z_i        (normal_z_i),
    .vertex_x_i        (vertex_x_i),
    .vertex_y_i        (vertex_y_i),
    .vertex_z_i        (vertex_z_i),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .point_z_i         (point_z_i),
    .pipe_busy_o       (pipe_busy),
    .inside_res_o      (inside_res_o),
    .penetration_o     (penetration_o),
    .contact_normal_x_o(contact_normal_x_o),
    .contact_normal_y_o(contact_normal_y_o),
    .contact_normal_z_o(contact_normal_z_o)
  );

endmodule

`default_nettype wire

// ===== design/pcpc_checker.sv =====
// port checker for the contact core and its bind to the top level
// depends on point_convex_polyhedron_contact_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "point_convex_polyhedron_contact_core_macros.svh"

module pcpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        operation_i,
  input wire logic        done_o,
  input wire logic        inside_res_o,
  input wire logic [31:0] penetration_o,
  input wire logic [31:0] contact_normal_x_o,
  input wire logic [31:0] contact_normal_y_o,
  input wire logic [31:0] contact_normal_z_o
);

  `PCPC_ASSERT_ALWAYS(a_done_while_busy, clk_i, done_o |-> busy, "done outside a query")
  `PCPC_ASSERT(a_query_goes_busy, clk_i, rst_ni, (start && !busy && operation_i) |=> busy, "query not started")
  `PCPC_ASSERT(a_load_stays_idle, clk_i, rst_ni, (start && !busy && !operation_i) |=> (!busy && !done_o), "load item made the block busy")
  `PCPC_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> (!busy && !done_o), "done not followed by idle")
  `PCPC_ASSERT(a_outside_zero, clk_i, rst_ni, (done_o && !inside_res_o) |-> (penetration_o == 32'd0 && contact_normal_x_o == 32'd0 && contact_normal_y_o == 32'd0 && contact_normal_z_o == 32'd0), "outside result not zero")

endmodule

bind point_convex_polyhedron_contact_core pcpc_checker u_pcpc_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for point_convex_polyhedron_contact_core, face loads and point queries
// depends on pcpc_pkg and the core; results are checked against a local face table predictor

module tb_top;

  localparam int unsigned FACE_SLOTS    = 64;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned ITEM_TARGET   = 500;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  typedef struct packed {
    logic        op;
    logic [5:0]  slot;
    logic [31:0] nx, ny, nz, vx, vy, vz, px, py, pz;
  } face_item_t;

  typedef struct packed {
    logic        in_hull;
    logic [31:0] pen, cnx, cny, cnz;
  } contact_t;

  typedef struct packed {
    logic       is_cfg;
    logic [6:0] cfg_val;
    logic       fixed;   // expected contact typed in the row
    face_item_t item;
    contact_t   want;
  } dir_row_t;

  localparam contact_t MISS = '0;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic        cfg_we_i     = 1'b0;
  logic [6:0]  cfg_wdata_i  = '0;
  logic        operation_i  = pcpc_pkg::OP_LOAD;
  logic [5:0]  face_index_i = '0;
  logic [31:0] normal_x_i   = '0;
  logic [31:0] normal_y_i   = '0;
  logic [31:0] normal_z_i   = '0;
  logic [31:0] vertex_x_i   = '0;
  logic [31:0] vertex_y_i   = '0;
  logic [31:0] vertex_z_i   = '0;
  logic [31:0] point_x_i    = '0;
  logic [31:0] point_y_i    = '0;
  logic [31:0] point_z_i    = '0;
  logic        done_o;
  logic        inside_res_o;
  logic [31:0] penetration_o;
  logic [31:0] contact_normal_x_o;
  logic [31:0] contact_normal_y_o;
  logic [31:0] contact_normal_z_o;

  point_convex_polyhedron_contact_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .operation_i        (operation_i),
    .face_index_i       (face_index_i),
    .normal_x_i         (normal_x_i),
    .normal_y_i         (normal_y_i),
    .normal_z_i         (normal_z_i),
    .vertex_x_i         (vertex_x_i),
    .vertex_y_i         (vertex_y_i),
    .vertex_z_i         (vertex_z_i),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .point_z_i          (point_z_i),
    .done_o             (done_o),
    .inside_res_o       (inside_res_o),
    .penetration_o      (penetration_o),
    .contact_normal_x_o (contact_normal_x_o),
    .contact_normal_y_o (contact_normal_y_o),
    .contact_normal_z_o (contact_normal_z_o)
  );

  // local copy of the face table and the face count
  logic signed [31:0] tab_nx [FACE_SLOTS];
  logic signed [31:0] tab_ny [FACE_SLOTS];
  logic signed [31:0] tab_nz [FACE_SLOTS];
  logic signed [31:0] tab_vx [FACE_SLOTS];
  logic signed [31:0] tab_vy [FACE_SLOTS];
  logic signed [31:0] tab_vz [FACE_SLOTS];
  logic [6:0]         face_count_q = 7'd1;

  contact_t pending_contacts[$];
  dir_row_t dir_rows[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int loads_sent     = 0;
  int queries_sent   = 0;
  int inside_seen    = 0;
  int outside_seen   = 0;
  int cfg_writes     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // floor(n . (v - p) / 2^16), saturated to 32 bits
  function automatic logic signed [31:0] face_depth(int f, logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
    logic signed [95:0] acc, n96, d96;
    acc = '0;
    n96 = 96'(tab_nx[f]);
    d96 = 96'(tab_vx[f]) - 96'(px);
    acc = acc + n96 * d96;
    n96 = 96'(tab_ny[f]);
    d96 = 96'(tab_vy[f]) - 96'(py);
    acc = acc + n96 * d96;
    n96 = 96'(tab_nz[f]);
    d96 = 96'(tab_vz[f]) - 96'(pz);
    acc = acc + n96 * d96;
    acc = acc >>> 16;
    if (acc > 96'sd2147483647) return 32'sh7fff_ffff;
    if (acc < -96'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic contact_t predict_contact(face_item_t it);
    contact_t           c;
    logic signed [31:0] d, best;
    int                 n;
    bit                 have;
    c = '0;
    n = (face_count_q > 7'(FACE_SLOTS)) ? int'(FACE_SLOTS) : int'(face_count_q);
    best = 32'sh7fff_ffff;
    have = 1'b0;
    for (int f = 0; f < n; f++) begin
      d = face_depth(f, it.px, it.py, it.pz);
      if (d < 0) return MISS;
      // strict compare keeps the first face on ties
      if (!have || d < best) begin
        have = 1'b1;
        best = d;
        c.cnx = tab_nx[f];
        c.cny = tab_ny[f];
        c.cnz = tab_nz[f];
      end
    end
    c.in_hull = 1'b1;
    c.pen = -best;
    return c;
  endfunction

  function automatic void store_face(face_item_t it);
    tab_nx[it.slot] = it.nx;
    tab_ny[it.slot] = it.ny;
    tab_nz[it.slot] = it.nz;
    tab_vx[it.slot] = it.vx;
    tab_vy[it.slot] = it.vy;
    tab_vz[it.slot] = it.vz;
  endfunction

  function automatic int q_rand(int span);
    int r;
    r = int'($urandom_range(0, 2 * span)) - span;
    return r;
  endfunction

  function automatic face_item_t noise_item();
    face_item_t it;
    it.op   = 1'($urandom_range(0, 1));
    it.slot = 6'($urandom);
    it.nx   = $urandom;
    it.ny   = $urandom;
    it.nz   = $urandom;
    it.vx   = $urandom;
    it.vy   = $urandom;
    it.vz   = $urandom;
    it.px   = $urandom;
    it.py   = $urandom;
    it.pz   = $urandom;
    return it;
  endfunction

  // vertex on the normal ray keeps the origin inside every face
  function automatic face_item_t shape_face(logic [5:0] s);
    face_item_t it;
    int         k, nx, ny, nz;
    it = noise_item();
    k  = $urandom_range(1, 4);
    nx = q_rand(65536);
    ny = q_rand(65536);
    nz = q_rand(65536);
    it.op   = pcpc_pkg::OP_LOAD;
    it.slot = s;
    it.nx   = nx;
    it.ny   = ny;
    it.nz   = nz;
    it.vx   = nx * k;
    it.vy   = ny * k;
    it.vz   = nz * k;
    return it;
  endfunction

  function automatic face_item_t shape_query();
    face_item_t it;
    int         span;
    it   = noise_item();
    span = ($urandom_range(0, 3) == 0) ? 196608 : 32768;
    it.op = pcpc_pkg::OP_QUERY;
    it.px = q_rand(span);
    it.py = q_rand(span);
    it.pz = q_rand(span);
    return it;
  endfunction

  function automatic contact_t contact_of(logic ins, logic [31:0] pen, logic [31:0] x,
                                          logic [31:0] y, logic [31:0] z);
    contact_t c;
    c = {ins, pen, x, y, z};
    return c;
  endfunction

  function automatic void row_load(logic [5:0] s, logic [31:0] nx, ny, nz, vx, vy, vz);
    dir_row_t r;
    r = '0;
    r.item = noise_item();
    r.item.op   = pcpc_pkg::OP_LOAD;
    r.item.slot = s;
    r.item.nx   = nx;
    r.item.ny   = ny;
    r.item.nz   = nz;
    r.item.vx   = vx;
    r.item.vy   = vy;
    r.item.vz   = vz;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_query(logic [31:0] px, py, pz, logic fixed, contact_t want);
    dir_row_t r;
    r = '0;
    r.item = noise_item();
    r.item.op = pcpc_pkg::OP_QUERY;
    r.item.px = px;
    r.item.py = py;
    r.item.pz = pz;
    r.fixed   = fixed;
    r.want    = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_cfg(logic [6:0] v);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic send_item(face_item_t it, logic fixed, contact_t want);
    contact_t c;
    operation_i  <= it.op;
    face_index_i <= it.slot;
    normal_x_i   <= it.nx;
    normal_y_i   <= it.ny;
    normal_z_i   <= it.nz;
    vertex_x_i   <= it.vx;
    vertex_y_i   <= it.vy;
    vertex_z_i   <= it.vz;
    point_x_i    <= it.px;
    point_y_i    <= it.py;
    point_z_i    <= it.pz;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (it.op == pcpc_pkg::OP_LOAD) begin
      store_face(it);
      loads_sent++;
    end else begin
      c = fixed ? want : predict_contact(it);
      pending_contacts.insert(pending_contacts.size(), c);
      queries_sent++;
    end
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // only written once the block is drained and the last query has retired
  task automatic set_face_count(logic [6:0] val);
    start <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    face_count_q = val;
    cfg_writes++;
  endtask

  always @(posedge clk_i) begin
    contact_t w;
    if (rst_ni && done_o) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("result with no query pending", penetration_o, '0);
      end else begin
        w = pending_contacts.pop_front();
        if (inside_res_o !== w.in_hull)
          report_mismatch("inside_res", 32'(inside_res_o), 32'(w.in_hull));
        if (penetration_o !== w.pen)
          report_mismatch("penetration", penetration_o, w.pen);
        if (contact_normal_x_o !== w.cnx)
          report_mismatch("contact_normal_x", contact_normal_x_o, w.cnx);
        if (contact_normal_y_o !== w.cny)
          report_mismatch("contact_normal_y", contact_normal_y_o, w.cny);
        if (contact_normal_z_o !== w.cnz)
          report_mismatch("contact_normal_z", contact_normal_z_o, w.cnz);
        if (w.in_hull) inside_seen++;
        else outside_seen++;
      end
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    face_item_t it;
    int         dir_count, phase, phase_items, pick, late_mark;
    bit         calm;

    // face count stays at its reset value of one until the first write
    row_load(0, ONE, 0, 0, ONE, 0, 0);
    row_query(0, 0, 0, 1'b1, contact_of(1'b1, 32'hffff_0000, ONE, 0, 0));
    row_query(2 * ONE, 0, 0, 1'b1, MISS);
    row_query(ONE, 0, 0, 1'b1, contact_of(1'b1, 0, ONE, 0, 0));
    row_query(0, MAXV, MINV, 1'b1, contact_of(1'b1, 32'hffff_0000, ONE, 0, 0));
    // saturation at both ends of the depth range
    row_load(0, MAXV, 0, 0, MAXV, 0, 0);
    row_query(MINV, $urandom, $urandom, 1'b1, contact_of(1'b1, 32'h8000_0001, MAXV, 0, 0));
    row_load(0, MINV, 0, 0, MINV, 0, 0);
    row_query(MAXV, 0, 0, 1'b1, contact_of(1'b1, 32'h8000_0001, MINV, 0, 0));
    row_query(MINV, MAXV, MINV, 1'b1, contact_of(1'b1, 0, MINV, 0, 0));
    row_load(0, MINV, MINV, MINV, MAXV, MAXV, MAXV);
    row_query(MINV, MINV, MINV, 1'b1, MISS);
    // unit cube corner faces, ties go to the lower face
    row_load(0, ONE, 0, 0, ONE, 0, 0);
    row_load(1, 0, ONE, 0, 0, ONE, 0);
    row_load(2, 0, 0, ONE, 0, 0, HALF);
    row_cfg(2);
    row_query(0, 0, 0, 1'b1, contact_of(1'b1, 32'hffff_0000, ONE, 0, 0));
    row_cfg(3);
    row_query(0, 0, 0, 1'b1, contact_of(1'b1, 32'hffff_8000, 0, 0, ONE));
    row_query(0, 0, ONE, 1'b1, MISS);
    row_query(0, HALF, 0, 1'b1, contact_of(1'b1, 32'hffff_8000, 0, ONE, 0));
    row_query(32'h0000_4000, 32'hffff_4000, 32'h0000_1999, 1'b0, MISS);
    row_load(63, '1, '1, '1, '1, '1, '1);
    // no face walked at all
    row_cfg(0);
    row_query($urandom, $urandom, $urandom, 1'b1, contact_of(1'b1, 32'h8000_0001, 0, 0, 0));
    dir_count = dir_rows.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        set_face_count(row.cfg_val);
      end else begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 14));
        send_item(row.item, row.fixed, row.want);
      end
    end

    // every slot written before the random phase queries any face
    for (int s = 0; s < FACE_SLOTS; s++) send_item(shape_face(6'(s)), 1'b0, MISS);

    late_mark = dir_count + FACE_SLOTS + (ITEM_TARGET * 9) / 10;
    phase = 0;
    while (items_sent < dir_count + FACE_SLOTS + ITEM_TARGET) begin
      // no face count change, and so no drain, in the closing stretch
      if (items_sent <= late_mark) begin
        pick = $urandom_range(0, 9);
        if (phase == 0) set_face_count(7'd127);
        else if (phase == 1) set_face_count(7'd64);
        else if (pick == 0) set_face_count(7'd0);
        else if (pick == 1) set_face_count(7'd64);
        else if (pick == 2) set_face_count(7'($urandom_range(65, 127)));
        else if (pick == 3) set_face_count(7'($urandom_range(9, 63)));
        else set_face_count(7'($urandom_range(1, 8)));
      end
      phase++;
      calm = ($urandom_range(0, 3) == 0) || (items_sent > late_mark);
      phase_items = $urandom_range(15, 40);
      repeat (phase_items) begin
        if (!calm && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 14));
        pick = $urandom_range(0, 9);
        if (pick < 7) it = shape_query();
        else if (pick < 9) it = shape_face(6'($urandom_range(0, FACE_SLOTS - 1)));
        else it = noise_item();
        send_item(it, 1'b0, MISS);
      end
    end

    start <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d face loads and %0d point queries (%0d inside, %0d outside)",
             loads_sent, queries_sent, inside_seen, outside_seen);
    $display("%0d face count settings written, %0d field mismatches", cfg_writes,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
